// ===== rtl/core/sliding_median_filter_core_assert.svh =====
// assertion macros shared by the sliding median filter checker
`ifndef SLIDING_MEDIAN_FILTER_CORE_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SMF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding median filter assertion failed");

// consequent checked in the cycle after the antecedent
`define SMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding median filter assertion failed");

`endif

// ===== rtl/core/smf_pkg.sv =====
// package with types, constants and codes of the sliding median filter
`default_nettype none

package smf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 5;
  localparam int SEEN_W         = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;
  localparam int MAX_WINDOW_DEF = 31;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd3;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  // register index as seen on paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } smf_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       window_error;
    logic                       last_result;
  } smf_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SORT,
    S_SORT_END,
    S_MED_OUT,
    S_MID_RD,
    S_MID_OUT,
    S_FL_RD,
    S_FL_OUT,
    S_ERR_OUT
  } smf_state_t;

  typedef enum logic [1:0] {
    RD_SORT,
    RD_MID,
    RD_FLUSH
  } smf_rd_src_t;

  typedef enum logic [1:0] {
    EM_MED,
    EM_RAW,
    EM_FLUSH,
    EM_ERR
  } smf_emit_t;

  typedef struct packed {
    logic        load;
    logic        sort_clear;
    logic        rd_en;
    smf_rd_src_t rd_src;
    logic        emit;
    smf_emit_t   emit_sel;
    logic        fl_load;
    logic        fl_dec;
  } smf_cmd_t;

  typedef struct packed {
    logic even;
    logic last;
    logic k_ge_h;
    logic k_ge_2h;
    logic h_zero;
    logic sort_last;
    logic fl_one;
    logic out_free;
  } smf_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/smf_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module smf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smf_datapath.sv =====
// datapath: sample ring, sorting cells, counters and result register
`default_nettype none

module smf_datapath import smf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [CFG_W-1:0] window_size,
  input  wire smf_sample_t sample_data,
  input  wire smf_cmd_t    cmd,
  output smf_status_t      st,
  output logic             result_valid,
  input  wire logic        result_stall,
  output smf_result_t      result_data
);

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int CMPW    = 9;
  localparam int MAX_ODD = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

  // latched item
  logic                       last_reg;
  logic                       even_reg;
  logic [WW-1:0]              w_reg;
  logic [AW-1:0]              h_reg;
  logic [SEEN_W-1:0]          k_reg;

  logic [SEEN_W-1:0] seen;
  logic [AW-1:0]     wp;
  logic [AW-1:0]     wp_next;
  logic [WW-1:0]     w_eff;

  logic [AW-1:0] cnt;
  logic [AW-1:0] fl_i;
  logic [AW-1:0] first_age;
  logic          ins_pend;

  logic [AW-1:0] age;
  logic [AW:0]   diff;
  logic [AW:0]   wrapped;
  logic [AW-1:0] raddr;
  logic [SAMPLE_W-1:0] rdata;

  logic signed [SAMPLE_W-1:0] cells      [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] cells_next [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]      gt;
  logic [WW-1:0]              n;
  logic signed [SAMPLE_W-1:0] ins_val;

  logic        res_valid_next;
  smf_result_t res_next;

  // clamp the width to the largest odd width that fits the store
  always_comb begin
    if (CMPW'(window_size) > CMPW'(MAX_ODD)) begin
      w_eff = WW'(MAX_ODD);
    end else begin
      w_eff = WW'(window_size);
    end
  end

  assign wp_next = (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      wp   <= '0;
    end else if (cmd.load) begin
      wp <= wp_next;
      if (sample_data.last_sample) begin
        seen <= '0;
      end else if (seen != SEEN_MAX) begin
        seen <= seen + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_reg   <= sample_data.last_sample;
      even_reg   <= ~window_size[0];
      w_reg      <= w_eff;
      h_reg      <= AW'(w_eff >> 1);
      k_reg      <= seen;
    end
  end

  // status toward the controller
  always_comb begin
    st.even      = even_reg;
    st.last      = last_reg;
    st.k_ge_h    = CMPW'(k_reg) >= CMPW'(h_reg);
    st.k_ge_2h   = CMPW'(k_reg) >= (CMPW'(w_reg) - CMPW'(1));
    st.h_zero    = (h_reg == '0);
    st.sort_last = (cnt == AW'(w_reg - WW'(1)));
    st.fl_one    = (fl_i == AW'(1));
    st.out_free  = ~result_valid | ~result_stall;
  end

  assign first_age = st.k_ge_h ? h_reg : AW'(CMPW'(k_reg) + CMPW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      fl_i     <= '0;
      ins_pend <= 1'b0;
    end else begin
      ins_pend <= cmd.rd_en && (cmd.rd_src == RD_SORT);
      if (cmd.sort_clear) begin
        cnt <= '0;
      end else if (cmd.rd_en && (cmd.rd_src == RD_SORT)) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.fl_load) begin
        fl_i <= first_age;
      end else if (cmd.fl_dec) begin
        fl_i <= fl_i - AW'(1);
      end
    end
  end

  // age to ring address, wrapping below zero
  always_comb begin
    case (cmd.rd_src)
      RD_SORT:  age = cnt;
      RD_MID:   age = h_reg;
      RD_FLUSH: age = fl_i - AW'(1);
      default:  age = '0;
    endcase
    diff    = {1'b0, wp} - {1'b0, age};
    wrapped = diff + (AW+1)'(MAX_WINDOW);
    raddr   = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];
  end

  smf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wp_next),
    .wdata (sample_data.sample),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sorted cells, ascending; cells at or past the fill count act as +inf
  assign ins_val = $signed(rdata);

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      gt[j] = (WW'(j) >= n) || (cells[j] > ins_val);
    end
    cells_next[0] = gt[0] ? ins_val : cells[0];
    for (int j = 1; j < MAX_WINDOW; j++) begin
      if (!gt[j]) begin
        cells_next[j] = cells[j];
      end else if (!gt[j-1]) begin
        cells_next[j] = ins_val;
      end else begin
        cells_next[j] = cells[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.sort_clear) begin
      n <= '0;
    end else if (ins_pend) begin
      n <= n + WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ins_pend) begin
      cells <= cells_next;
    end
  end

  // result register
  always_comb begin
    res_next = result_data;
    case (cmd.emit_sel)
      EM_MED: begin
        res_next.value        = cells[h_reg];
        res_next.window_error = 1'b0;
        res_next.last_result  = last_reg & st.h_zero;
      end
      EM_RAW: begin
        res_next.value        = $signed(rdata);
        res_next.window_error = 1'b0;
        res_next.last_result  = last_reg & st.h_zero;
      end
      EM_FLUSH: begin
        res_next.value        = $signed(rdata);
        res_next.window_error = 1'b0;
        res_next.last_result  = st.fl_one;
      end
      EM_ERR: begin
        res_next.value        = '0;
        res_next.window_error = 1'b1;
        res_next.last_result  = 1'b1;
      end
      default: begin
        res_next.value        = '0;
        res_next.window_error = 1'b0;
        res_next.last_result  = 1'b0;
      end
    endcase
    if (cmd.emit) begin
      res_valid_next = 1'b1;
    end else if (!result_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smf_ctrl.sv =====
// controller state machine sequencing one sample at a time
`default_nettype none

module smf_ctrl import smf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire smf_status_t st,
  output smf_cmd_t         cmd
);

  smf_state_t state;
  smf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.rd_src   = RD_SORT;
    cmd.emit_sel = EM_MED;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.even) begin
          state_next = st.last ? S_ERR_OUT : S_IDLE;
        end else if (st.k_ge_h) begin
          if (st.k_ge_2h) begin
            cmd.sort_clear = 1'b1;
            state_next     = S_SORT;
          end else begin
            state_next = S_MID_RD;
          end
        end else if (st.last) begin
          cmd.fl_load = 1'b1;
          state_next  = S_FL_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SORT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_SORT;
        if (st.sort_last) begin
          state_next = S_SORT_END;
        end
      end
      S_SORT_END: begin
        state_next = S_MED_OUT;
      end
      S_MED_OUT, S_MID_OUT: begin
        cmd.emit_sel = (state == S_MED_OUT) ? EM_MED : EM_RAW;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last && !st.h_zero) begin
            cmd.fl_load = 1'b1;
            state_next  = S_FL_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_MID_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_MID;
        state_next = S_MID_OUT;
      end
      S_FL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_FLUSH;
        state_next = S_FL_OUT;
      end
      S_FL_OUT: begin
        cmd.emit_sel = EM_FLUSH;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.fl_dec = 1'b1;
          state_next = st.fl_one ? S_IDLE : S_FL_RD;
        end
      end
      S_ERR_OUT: begin
        cmd.emit_sel = EM_ERR;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sliding_median_filter_core.sv =====
// top level of the sliding median filter: config register, controller, datapath
//
//   channel  direction  handshake                      payload
//   sample   in         sample_valid / sample_stall    smf_sample_t (sample, last_sample)
//   result   out        result_valid / result_stall    smf_result_t (value, error, last)
//   config   in         apb psel / penable / pready    window_size at byte address 0
//
// per sample after the load: decide only, with an even width or before h = w/2 samples
// are in; from then until 2h are in, read and emit the middle sample raw; once w are in,
// sort by one ring read per cycle into the sorting cells, then emit the median; a final
// sample adds a read and emit per flushed tail result, or an emit of the error result
// reset is synchronous and active high; no clearing pass, the ring needs none
// a stalled result holds in the output register and the sequencer waits on it
`default_nettype none

module sliding_median_filter_core import smf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // sample channel
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire smf_sample_t        sample_data,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output smf_result_t             result_data,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [CFG_W-1:0] window_size;
  smf_cmd_t         cmd;
  smf_status_t      st;

  // apb access phase writes the window width, low address bits are byte lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  // readback, unmapped addresses read as zero
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                  {{(PDATA_W-CFG_W){1'b0}}, window_size} : '0;
  assign pready = 1'b1;

  // sequencer: one sample at a time, stalls the sample channel while busy
  smf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // ring of recent samples, sorting cells and the result register
  smf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .window_size  (window_size),
    .sample_data  (sample_data),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/smf_checker.sv =====
// port level checker for the sliding median filter core and its bind
`default_nettype none

`include "sliding_median_filter_core_assert.svh"

module smf_checker import smf_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_valid,
  input wire logic        sample_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire smf_result_t result_data
);

  // a stalled result transaction keeps its payload
  `SMF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data))

  // an error result always closes the sequence
  `SMF_ASSERT_SAME(a_error_last, result_valid && result_data.window_error, result_data.last_result)

  // an error result carries a zero value
  `SMF_ASSERT_SAME(a_error_zero, result_valid && result_data.window_error, result_data.value == '0)

  // an accepted sample transaction puts the sequencer into a busy state that stalls the sample channel
  `SMF_ASSERT_NEXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall)

endmodule

bind sliding_median_filter_core smf_checker u_smf_checker (.*);

`default_nettype wire

// ===== tb/sv/sliding_median_filter_core_test.sv =====
// self-checking testbench for the sliding median filter core
`timescale 1ns / 1ps

module sliding_median_filter_core_test import smf_pkg::*;;

  localparam int HIST_DEPTH = 31;
  // worst sample: a full sort plus the flush of the tail results
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 220;
  localparam int NUM_ROWS = 22;

  // one row of the directed table: optional width write before the sample,
  // and a hand-written result where it is obvious from the behavior
  typedef struct {
    bit                         set_w;
    logic [CFG_W-1:0]           w;
    logic signed [SAMPLE_W-1:0] s;
    logic                       last;
    bit                         typed;
    smf_result_t                res;
  } row_t;

  // what the sender knows about a sample that has not yet been accepted
  typedef struct {
    bit          typed;
    smf_result_t res;
  } in_flight_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  smf_sample_t       sample_data = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  smf_result_t       result_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  sliding_median_filter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // predictor state: sample history (entry 0 newest), count, width register
  logic signed [SAMPLE_W-1:0] sample_hist [HIST_DEPTH];
  logic [SEEN_W-1:0]          seen_count;
  logic [CFG_W-1:0]           window_width;

  smf_result_t expected_results [$];
  smf_result_t step_results [$];
  in_flight_t  in_flight_q [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;
  int          result_wait = 0;
  int          rand_items = 0;

  // directed table: reset width, extremes, width 1, even widths, a sequence
  // shorter than the window and a width change in the middle of a sequence
  row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 5'd0,  16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, 1'b0, 1'b1}},
    '{1'b0, 5'd0,  16'sh8000, 1'b1, 1'b1, '{16'sh8000, 1'b0, 1'b1}},
    '{1'b0, 5'd0,  16'sd5,    1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sh7FFF, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd0,    1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd100,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  -16'sd1,   1'b1, 1'b0, '0},
    '{1'b1, 5'd1,  16'sh7FFF, 1'b0, 1'b1, '{16'sh7FFF, 1'b0, 1'b0}},
    '{1'b0, 5'd0,  16'sh8000, 1'b1, 1'b1, '{16'sh8000, 1'b0, 1'b1}},
    '{1'b1, 5'd4,  16'sd1234, 1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  -16'sd5,   1'b1, 1'b1, '{16'sd0, 1'b1, 1'b1}},
    '{1'b1, 5'd0,  16'sd7,    1'b1, 1'b1, '{16'sd0, 1'b1, 1'b1}},
    '{1'b1, 5'd31, 16'sd1,    1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd2,    1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd3,    1'b1, 1'b0, '0},
    '{1'b1, 5'd5,  16'sd10,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  -16'sd20,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd30,   1'b0, 1'b0, '0},
    '{1'b1, 5'd3,  -16'sd40,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd50,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  16'sd60,   1'b1, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard limit well above the slowest correct run
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic smf_result_t make_result(logic signed [SAMPLE_W-1:0] v, logic err,
                                              logic lst);
    smf_result_t r;
    r.value = v;
    r.window_error = err;
    r.last_result = lst;
    return r;
  endfunction

  // median of the w newest samples, by insertion sort
  function automatic logic signed [SAMPLE_W-1:0] window_median(int w);
    logic signed [SAMPLE_W-1:0] sorted [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] v;
    int j;
    for (int i = 0; i < w; i++) begin
      v = sample_hist[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[w/2];
  endfunction

  // advance the filter by one sample, results go to step_results
  function automatic void predict_filter(smf_sample_t item);
    int k;
    int h;
    int w;
    int first_age;
    for (int i = HIST_DEPTH - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
    sample_hist[0] = item.sample;
    k = seen_count;
    seen_count = (seen_count < SEEN_MAX) ? seen_count + 1'b1 : SEEN_MAX;
    w = window_width;
    // even width: count and store only, one error result on the final sample
    if (w % 2 == 0) begin
      if (item.last_sample) begin
        step_results.push_back(make_result('0, 1'b1, 1'b1));
        seen_count = '0;
      end
      return;
    end
    if (w > HIST_DEPTH) w = HIST_DEPTH;
    h = w / 2;
    // steady rule: raw while the window fills, median once it is full
    if (k >= h) begin
      step_results.push_back(make_result((k >= 2*h) ? window_median(w) : sample_hist[h],
                                         1'b0, item.last_sample && h == 0));
    end
    // final sample: flush the raw tail, oldest first
    if (item.last_sample) begin
      first_age = (k >= h) ? h : k + 1;
      for (int i = first_age; i > 0; i--)
        step_results.push_back(make_result(sample_hist[i-1], 1'b0, i == 1));
      seen_count = '0;
    end
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // monitor for both channels; sample side first so an expectation exists
  // before its result could ever be seen in the same cycle
  always @(posedge clk) begin
    in_flight_t  meta;
    smf_result_t want;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        meta = in_flight_q.pop_front();
        step_results.delete();
        predict_filter(sample_data);
        if (meta.typed) expected_results.push_back(meta.res);
        else foreach (step_results[i]) expected_results.push_back(step_results[i]);
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual value %0d",
                   $time, $signed(result_data.value));
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("value", $signed(want.value), $signed(result_data.value));
          check_field("window_error", want.window_error, result_data.window_error);
          check_field("last_result", want.last_result, result_data.last_result);
        end
      end
    end
  end

  // receiver back-pressure: a fresh wait is drawn after every accepted result
  always @(posedge clk) begin
    if (rst) begin
      result_wait = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_wait = no_idle ? 0 : $urandom_range(0, 9);
      else if (result_wait > 0) result_wait--;
      result_stall <= (result_wait != 0);
    end
  end

  // one sample transaction, with a random gap in front of it
  task automatic drive_sample(smf_sample_t item, bit typed, smf_result_t res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_flight_q.push_back('{typed, res});
    sample_valid <= 1'b1;
    sample_data <= item;
    do @(posedge clk); while (sample_stall);
  endtask

  // hold the sender until every expected result is in, then let the core settle
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (in_flight_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the width register, only while the core is idle
  task automatic write_width(logic [CFG_W-1:0] w);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_WINDOW_SIZE, 2'b00};
    pwdata <= {27'($urandom), w};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window_width = w;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int flavor);
    logic signed [SAMPLE_W-1:0] v;
    case (flavor)
      0: v = $signed(16'($urandom_range(0, 65535)));
      // narrow range so the window holds many equal values
      1: v = $signed(16'($urandom_range(0, 8))) - 16'sd4;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sd0;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // one sequence of random content; optionally the width is rewritten halfway
  task automatic run_sequence(int len, int flavor, bit change_mid);
    smf_sample_t item;
    for (int i = 0; i < len; i++) begin
      if (change_mid && i == len / 2)
        write_width(5'($urandom_range(0, 15) * 2 + 1));
      item.sample = pick_sample(flavor);
      item.last_sample = (i == len - 1);
      drive_sample(item, 1'b0, '0);
      rand_items++;
    end
  endtask

  initial begin
    smf_sample_t      item;
    logic [CFG_W-1:0] w;
    int               len;
    int               r;
    seen_count = '0;
    window_width = WINDOW_SIZE_RESET;
    foreach (sample_hist[i]) sample_hist[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].set_w) write_width(directed_rows[i].w);
      item.sample = directed_rows[i].s;
      item.last_sample = directed_rows[i].last;
      drive_sample(item, directed_rows[i].typed, directed_rows[i].res);
    end

    // a long sequence at the widest window runs the sample count into saturation
    write_width(5'd31);
    run_sequence(70, 0, 1'b0);

    // random phases: mostly odd widths with sequences that fill the window
    while (rand_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) w = 5'($urandom_range(0, 15) * 2);
      else if (r == 1) w = 5'd31;
      else if (r == 2) w = 5'd1;
      else w = 5'($urandom_range(0, 15) * 2 + 1);
      write_width(w);
      if (w[0] == 1'b0) len = $urandom_range(1, 6);
      else if ($urandom_range(0, 3) != 0) len = $urandom_range(w, w + 12);
      else len = $urandom_range(1, w);
      run_sequence(len, $urandom_range(0, 2), w[0] && len > 3 && $urandom_range(0, 5) == 0);
    end
    no_idle = 1'b0;

    // wait for the tail and any stray result
    drain_results();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_ram.sv
rtl/core/smf_datapath.sv
rtl/core/smf_ctrl.sv
rtl/core/sliding_median_filter_core.sv
rtl/core/smf_checker.sv
tb/sv/sliding_median_filter_core_test.sv
